// File: rtl/dmpid_pkg.sv
// ----------------------------------------------------------------------------
// dmpid_pkg
// Shared types and constants of the dual motor incremental PID speed block.
// ----------------------------------------------------------------------------
package dmpid_pkg;

   localparam int ImageRows = 60;

   localparam logic [25:0] GAIN_PROP_RESET  = 26'd4915200;
   localparam logic [25:0] GAIN_INTEG_RESET = 26'd39;
   localparam logic [25:0] GAIN_DERIV_RESET = 26'd589824;
   localparam logic [9:0]  DUTY_MAX_RESET   = 10'd990;

   localparam logic [25:0] FIXED_KP = 26'd2621440;
   localparam logic [25:0] FIXED_KI = 26'd39;
   localparam logic [25:0] FIXED_KD = 26'd655360;

   // Reciprocals for the divisions by 10 and by 100. With a shift of 19 the
   // quotient is exact for magnitudes below 43690, well above the dividends.
   localparam logic signed [47:0] RECIP_TEN     = 48'sd52429;
   localparam logic signed [47:0] RECIP_HUNDRED = 48'sd5243;
   localparam int                 RecipShift    = 19;

   typedef enum logic [1:0] {
      REG_GAIN_PROP  = 2'd0,
      REG_GAIN_INTEG = 2'd1,
      REG_GAIN_DERIV = 2'd2,
      REG_DUTY_MAX   = 2'd3
   } reg_index_type;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic signed [47:0] a;
      logic signed [47:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic signed [47:0] result;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BASE_DIV, ST_BASE_WAIT,
      ST_Q_MUL,  ST_Q_WAIT,
      ST_SQ_MUL, ST_SQ_WAIT,
      ST_ES_MUL, ST_ES_WAIT,
      ST_LDIV,   ST_LDIV_WAIT,
      ST_RDIV,   ST_RDIV_WAIT,
      ST_FDIV_L, ST_FDIV_L_WAIT,
      ST_FDIV_R, ST_FDIV_R_WAIT,
      ST_PID_M0, ST_PID_W0,
      ST_PID_M1, ST_PID_W1,
      ST_PID_M2, ST_PID_W2,
      ST_PID_ACC,
      ST_OUT
   } state_type;

   function automatic logic signed [47:0] clamp48(input logic signed [47:0] v,
                                                  input logic signed [47:0] lo,
                                                  input logic signed [47:0] hi);
      logic signed [47:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

// File: rtl/dmpid_alu.sv
// ----------------------------------------------------------------------------
// dmpid_alu
// Shared arithmetic unit: a radix-2 shift-add multiplier and a restoring
// divider that truncates toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module dmpid_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  dmpid_pkg::alu_req_type req,
   output dmpid_pkg::alu_rsp_type rsp
);
   import dmpid_pkg::*;

   logic               busy_ff, busy_in;
   alu_op_type         op_ff, op_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [47:0]        a_ff, a_in;      // multiplicand or dividend magnitude
   logic [47:0]        b_ff, b_in;      // multiplier or divisor magnitude
   logic [47:0]        acc_ff, acc_in;  // product or remainder
   logic [47:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   logic signed [47:0] res_ff, res_in;
   logic [48:0]        trial;
   logic [47:0]        rem_sh;

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      rem_sh  = {acc_ff[46:0], a_ff[47]};
      trial   = {1'b0, rem_sh} - {1'b0, b_ff};
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            op_in   = req.op;
            cnt_in  = 6'd0;
            acc_in  = '0;
            quo_in  = '0;
            a_in    = req.a[47] ? 48'(-req.a) : req.a;
            b_in    = req.b[47] ? 48'(-req.b) : req.b;
            neg_in  = req.a[47] ^ req.b[47];
         end
      end else begin
         if (op_ff == OP_MUL) begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[46:0], 1'b0};
            b_in = {1'b0, b_ff[47:1]};
         end else begin
            a_in = {a_ff[46:0], 1'b0};
            if (!trial[48]) begin
               acc_in = trial[47:0];
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == OP_MUL) begin
               res_in = neg_ff ? -$signed(acc_in) : $signed(acc_in);
            end else begin
               res_in = neg_ff ? -$signed(quo_in) : $signed(quo_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held two cycles");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff) else $error("done while busy");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == 6'd0) else $error("count not cleared");
`endif

endmodule

// File: rtl/dual_motor_incremental_pid_speed.sv
// ----------------------------------------------------------------------------
// dual_motor_incremental_pid_speed
// Two-wheel target speed and incremental PID duty controller.
// ----------------------------------------------------------------------------
// Usage: one item per control period enters on the req_ channel (wheel speeds,
// line error and its previous value, end row, last valid row, mode bit). The
// block answers with one item on the rsp_ channel carrying both clamped duties
// and both wheel targets. The configuration port (APB style, always ready) writes and
// reads the three Q10.16 gains and the duty limit; writing a gain releases
// the fixed-mode gain latch.
// All arithmetic runs through one shared 48-bit unit that multiplies or
// divides one bit per cycle. The divisions by 10 and 100 are reciprocal
// multiplications. An item needs between 6 operations (fixed mode, small
// error) and 12 (dynamic mode with a differential split). req_ready is
// high only while the sequencer is idle; the next item is taken in the cycle
// after the result is loaded into the output register, even while the
// receiver stalls, but its result waits until the previous one is taken.
// Reset clears the history, accumulators, stored row, gain latch and restores
// the register defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module dual_motor_incremental_pid_speed (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_left_speed,
   input  logic signed [15:0] req_right_speed,
   input  logic signed [7:0]  req_line_error,
   input  logic signed [7:0]  req_prev_line_error,
   input  logic [5:0]         req_end_row,
   input  logic [5:0]         req_last_valid_row,
   input  logic               req_dynamic_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_left_duty,
   output logic [9:0]         rsp_right_duty,
   output logic [6:0]         rsp_left_target,
   output logic [6:0]         rsp_right_target,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dmpid_pkg::*;

   // Configuration registers.
   logic [25:0] kp_reg_ff, ki_reg_ff, kd_reg_ff;
   logic [9:0]  duty_max_ff;
   logic        latched_ff, latched_in;
   logic        cfg_wr;
   logic [1:0]  cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[3:2];

   always_comb begin
      case (reg_index_type'(cfg_idx))
         REG_GAIN_PROP:  prdata = {6'd0, kp_reg_ff};
         REG_GAIN_INTEG: prdata = {6'd0, ki_reg_ff};
         REG_GAIN_DERIV: prdata = {6'd0, kd_reg_ff};
         REG_DUTY_MAX:   prdata = {22'd0, duty_max_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_reg_ff   <= GAIN_PROP_RESET;
         ki_reg_ff   <= GAIN_INTEG_RESET;
         kd_reg_ff   <= GAIN_DERIV_RESET;
         duty_max_ff <= DUTY_MAX_RESET;
      end else if (cfg_wr && paddr[1:0] == 2'd0) begin
         case (reg_index_type'(cfg_idx))
            REG_GAIN_PROP:  kp_reg_ff   <= pwdata[25:0];
            REG_GAIN_INTEG: ki_reg_ff   <= pwdata[25:0];
            REG_GAIN_DERIV: kd_reg_ff   <= pwdata[25:0];
            REG_DUTY_MAX:   duty_max_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Sequencer state and item data.
   state_type          state_ff, state_in;
   logic signed [15:0] ls_ff, rs_ff;
   logic signed [7:0]  e_ff, p_ff;
   logic [5:0]         end_ff, last_ff;
   logic               dyn_ff;
   logic [5:0]         srow_ff, srow_in;
   logic signed [47:0] s_ff, s_in;
   logic signed [47:0] q_ff, q_in;
   logic signed [47:0] es_ff, es_in;
   logic signed [47:0] lt_ff, lt_in, rt_ff, rt_in;
   logic               wheel_ff, wheel_in;  // 0 right, 1 left
   logic signed [47:0] t_ff, t_in;
   logic signed [17:0] lh0_ff, lh1_ff, rh0_ff, rh1_ff;
   logic signed [17:0] lh0_in, lh1_in, rh0_in, rh1_in;
   logic [31:0]        lacc_ff, lacc_in, racc_ff, racc_in;
   logic [9:0]         ld_ff, ld_in, rd_ff, rd_in;
   logic               ovalid_ff, ovalid_in;
   logic [9:0]         old_ff, old_in, ord_ff, ord_in;
   logic [6:0]         olt_ff, olt_in, ort_ff, ort_in;

   alu_req_type areq;
   alu_rsp_type arsp;

   dmpid_alu u_alu (.clock(clock), .reset(reset), .req(areq), .rsp(arsp));

   // Derived values of the current item.
   logic signed [47:0] r_v, ae_v, base_num, d_v, e0_v, kp_v, ki_v, kd_v;
   logic signed [47:0] h1_v, h2_v, qt_v, acc_s, tgt_v, spd_v, new_acc;
   logic signed [47:0] rq_v;
   logic [31:0]        acc_sum;

   assign req_ready = (state_ff == ST_IDLE) && !(ovalid_ff && !rsp_ready && 1'b0);

   always_comb begin
      r_v  = 48'(clamp48(48'($signed({1'b0, end_ff})), 48'sd35, 48'sd55));
      ae_v = e_ff[7] ? -48'(e_ff) : 48'(e_ff);
      base_num = 48'sd12 * r_v + 48'sd100 * (r_v - 48'($signed({1'b0, srow_ff})))
                 - 48'sd3 * ae_v - 48'sd10 * (48'(e_ff) - 48'(p_ff));
      d_v  = 48'(ImageRows - 4) - 48'($signed({1'b0, last_ff}));
      kp_v = latched_ff ? 48'(FIXED_KP) : 48'($signed({1'b0, kp_reg_ff}));
      ki_v = latched_ff ? 48'(FIXED_KI) : 48'($signed({1'b0, ki_reg_ff}));
      kd_v = latched_ff ? 48'(FIXED_KD) : 48'($signed({1'b0, kd_reg_ff}));
      tgt_v = wheel_ff ? lt_ff : rt_ff;
      spd_v = wheel_ff ? 48'(ls_ff) : 48'(rs_ff);
      e0_v  = tgt_v - spd_v;
      h1_v  = wheel_ff ? 48'(lh0_ff) : 48'(rh0_ff);
      h2_v  = wheel_ff ? 48'(lh1_ff) : 48'(rh1_ff);
      qt_v  = t_ff[47] ? -48'((-t_ff) >>> 16) : (t_ff >>> 16);
      // Quotient of a reciprocal product, truncated toward zero.
      rq_v  = arsp.result[47] ? -48'((-arsp.result) >>> RecipShift)
                              : (arsp.result >>> RecipShift);
      acc_s = wheel_ff ? 48'($signed(lacc_ff)) : 48'($signed(racc_ff));
      acc_sum = 32'(acc_s) + 32'(qt_v);
      new_acc = 48'($signed(acc_sum));
   end

   always_comb begin
      state_in = state_ff;
      srow_in = srow_ff; s_in = s_ff; q_in = q_ff; es_in = es_ff;
      lt_in = lt_ff; rt_in = rt_ff; wheel_in = wheel_ff; t_in = t_ff;
      lh0_in = lh0_ff; lh1_in = lh1_ff; rh0_in = rh0_ff; rh1_in = rh1_ff;
      lacc_in = lacc_ff; racc_in = racc_ff; ld_in = ld_ff; rd_in = rd_ff;
      latched_in = latched_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      old_in = old_ff; ord_in = ord_ff; olt_in = olt_ff; ort_in = ort_ff;
      areq = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};

      if (cfg_wr && paddr[1:0] == 2'd0 &&
          (reg_index_type'(cfg_idx) == REG_GAIN_PROP ||
           reg_index_type'(cfg_idx) == REG_GAIN_INTEG ||
           reg_index_type'(cfg_idx) == REG_GAIN_DERIV)) begin
         latched_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BASE_DIV;
            end
         end
         ST_BASE_DIV: begin
            if (dyn_ff) begin
               // The division by 10 is a multiplication by its reciprocal.
               areq = '{start: 1'b1, op: OP_MUL, a: base_num, b: RECIP_TEN};
               state_in = ST_BASE_WAIT;
            end else begin
               latched_in = 1'b1;
               if (ae_v >= 48'sd10) begin
                  state_in = ST_FDIV_L;
               end else begin
                  lt_in = 48'sd45; rt_in = 48'sd45;
                  state_in = ST_PID_M0; wheel_in = 1'b0;
               end
            end
         end
         ST_BASE_WAIT: begin
            if (arsp.done) begin
               s_in = clamp48(rq_v, 48'sd35, 48'sd55);
               srow_in = 6'(r_v);
               if (ae_v >= 48'sd10) begin
                  state_in = ST_Q_MUL;
               end else begin
                  lt_in = clamp48(rq_v, 48'sd35, 48'sd55);
                  rt_in = clamp48(rq_v, 48'sd35, 48'sd55);
                  state_in = ST_PID_M0; wheel_in = 1'b0;
               end
            end
         end
         ST_Q_MUL: begin
            areq = '{start: 1'b1, op: OP_MUL, a: d_v, b: d_v};
            state_in = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (arsp.done) begin
               q_in = (arsp.result == 48'sd0) ? 48'sd1 : arsp.result;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            areq = '{start: 1'b1, op: OP_MUL, a: s_ff, b: q_ff};
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (arsp.done) begin
               t_in = arsp.result;
               state_in = ST_ES_MUL;
            end
         end
         ST_ES_MUL: begin
            areq = '{start: 1'b1, op: OP_MUL, a: 48'sd30 * 48'(e_ff), b: s_ff};
            state_in = ST_ES_WAIT;
         end
         ST_ES_WAIT: begin
            if (arsp.done) begin
               es_in = arsp.result;
               state_in = ST_LDIV;
            end
         end
         ST_LDIV: begin
            areq = '{start: 1'b1, op: OP_DIV, a: t_ff - es_ff, b: q_ff};
            state_in = ST_LDIV_WAIT;
         end
         ST_LDIV_WAIT: begin
            if (arsp.done) begin
               lt_in = clamp48(arsp.result, 48'sd5, 48'sd110);
               state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            areq = '{start: 1'b1, op: OP_DIV, a: t_ff + es_ff, b: q_ff};
            state_in = ST_RDIV_WAIT;
         end
         ST_RDIV_WAIT: begin
            if (arsp.done) begin
               rt_in = clamp48(arsp.result, 48'sd5, 48'sd110);
               state_in = ST_PID_M0; wheel_in = 1'b0;
            end
         end
         // The fixed-mode divisions by 100 also use a reciprocal product.
         ST_FDIV_L: begin
            areq = '{start: 1'b1, op: OP_MUL,
                     a: 48'sd4000 - 48'sd72 * 48'(e_ff), b: RECIP_HUNDRED};
            state_in = ST_FDIV_L_WAIT;
         end
         ST_FDIV_L_WAIT: begin
            if (arsp.done) begin
               lt_in = clamp48(rq_v, 48'sd20, 48'sd80);
               state_in = ST_FDIV_R;
            end
         end
         ST_FDIV_R: begin
            areq = '{start: 1'b1, op: OP_MUL,
                     a: 48'sd4000 + 48'sd72 * 48'(e_ff), b: RECIP_HUNDRED};
            state_in = ST_FDIV_R_WAIT;
         end
         ST_FDIV_R_WAIT: begin
            if (arsp.done) begin
               rt_in = clamp48(rq_v, 48'sd20, 48'sd80);
               state_in = ST_PID_M0; wheel_in = 1'b0;
            end
         end
         // PID step: t = (Kp+Ki+Kd)e0 - (Kp+2Kd)e1 + Kd e2, one product at a time.
         ST_PID_M0: begin
            areq = '{start: 1'b1, op: OP_MUL, a: kp_v + ki_v + kd_v, b: e0_v};
            state_in = ST_PID_W0;
         end
         ST_PID_W0: begin
            if (arsp.done) begin
               t_in = arsp.result;
               state_in = ST_PID_M1;
            end
         end
         ST_PID_M1: begin
            areq = '{start: 1'b1, op: OP_MUL, a: kp_v + 48'sd2 * kd_v, b: h1_v};
            state_in = ST_PID_W1;
         end
         ST_PID_W1: begin
            if (arsp.done) begin
               t_in = t_ff - arsp.result;
               state_in = ST_PID_M2;
            end
         end
         ST_PID_M2: begin
            areq = '{start: 1'b1, op: OP_MUL, a: kd_v, b: h2_v};
            state_in = ST_PID_W2;
         end
         ST_PID_W2: begin
            if (arsp.done) begin
               t_in = t_ff + arsp.result;
               state_in = ST_PID_ACC;
            end
         end
         ST_PID_ACC: begin
            if (wheel_ff) begin
               lacc_in = acc_sum;
               lh1_in = lh0_ff; lh0_in = 18'(e0_v);
            end else begin
               racc_in = acc_sum;
               rh1_in = rh0_ff; rh0_in = 18'(e0_v);
            end
            if (new_acc <= 48'sd0) begin
               if (wheel_ff) ld_in = '0; else rd_in = '0;
            end else if (new_acc >= 48'($signed({1'b0, duty_max_ff}))) begin
               if (wheel_ff) ld_in = duty_max_ff; else rd_in = duty_max_ff;
            end else begin
               if (wheel_ff) ld_in = 10'(new_acc); else rd_in = 10'(new_acc);
            end
            if (wheel_ff) begin
               state_in = ST_OUT;
            end else begin
               wheel_in = 1'b1;
               state_in = ST_PID_M0;
            end
         end
         ST_OUT: begin
            // Wait until the output register is free, then load it.
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in = 1'b1;
               old_in = ld_ff; ord_in = rd_ff;
               olt_in = 7'(lt_ff); ort_in = 7'(rt_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         srow_ff    <= '0;
         lh0_ff <= '0; lh1_ff <= '0; rh0_ff <= '0; rh1_ff <= '0;
         lacc_ff <= '0; racc_ff <= '0;
         latched_ff <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         srow_ff    <= srow_in;
         lh0_ff <= lh0_in; lh1_ff <= lh1_in; rh0_ff <= rh0_in; rh1_ff <= rh1_in;
         lacc_ff <= lacc_in; racc_ff <= racc_in;
         latched_ff <= latched_in;
         ovalid_ff  <= ovalid_in;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         ls_ff <= req_left_speed; rs_ff <= req_right_speed;
         e_ff <= req_line_error; p_ff <= req_prev_line_error;
         end_ff <= req_end_row; last_ff <= req_last_valid_row;
         dyn_ff <= req_dynamic_mode;
      end
      s_ff <= s_in; q_ff <= q_in; es_ff <= es_in;
      lt_ff <= lt_in; rt_ff <= rt_in; wheel_ff <= wheel_in; t_ff <= t_in;
      ld_ff <= ld_in; rd_ff <= rd_in;
      old_ff <= old_in; ord_ff <= ord_in; olt_ff <= olt_in; ort_ff <= ort_in;
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_left_duty    = old_ff;
   assign rsp_right_duty   = ord_ff;
   assign rsp_left_target  = olt_ff;
   assign rsp_right_target = ort_ff;

`ifndef ASSERT_OFF
   a_duty_l: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> ld_ff <= duty_max_ff) else $error("left duty over limit");
   a_duty_r: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> rd_ff <= duty_max_ff) else $error("right duty over limit");
   a_tgt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_target <= 7'd110 && rsp_right_target <= 7'd110)
      else $error("target out of range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
`endif

endmodule
